[sv/fspa_pkg.sv]
// Shared types and constants for the fixed-size pool allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package fspa_pkg;

	localparam int REGION_BYTES_DEF = 65536;
	localparam int HEADER_BYTES_DEF = 8;

	// Addresses are 16 bits, so the region can never reach past this.
	localparam int ADDR_SPACE = 65536;
	localparam int ELEM_ROUND = 3;
	localparam int HDR_ROUND  = 7;

	localparam int ADDR_W    = 16;
	localparam int LINK_AW   = 14;
	localparam int LINK_DEPTH = 16384;
	localparam int EB_W      = 13;
	localparam int EPC_W     = 11;
	localparam int SLOT_W    = 14;
	localparam int PROD_W    = SLOT_W + EPC_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int BUMP_W    = 17;
	localparam int BASE_W    = 18;
	localparam int FREE_W    = 15;
	localparam int CHUNK_W   = 14;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 13;
	localparam int OUT_DATA_W = 48;

	localparam logic [EB_W-1:0]  ELEM_BYTES_RST = 13'd8;
	localparam logic [EPC_W-1:0] ELEMS_PER_CHUNK_RST = 11'd16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMS_PER_CHUNK = 1'b1;

	// Request kinds.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_NULL_FREE = 2'd2,
		ST_OVER_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic latch_in;
		logic do_free;
		logic issue_read;
		logic mul;
		logic check;
		logic walk;
		logic pop;
		logic load_out;
	} fspa_cmd_t;

	typedef struct packed {
		logic op_free;
		logic head_zero;
		logic fits;
		logic walk_last;
	} fspa_sts_t;

endpackage

[sv/fspa_dp.sv]
// Datapath of the pool allocator: configuration registers, list head, counters,
// chunk carving arithmetic, the link store and the result register.
// Depends on fspa_pkg; driven by commands from fspa_ctrl.
module fspa_dp import fspa_pkg::*; #(
	parameter int REGION_BYTES = REGION_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_op,
	input  logic [ADDR_W-1:0]      in_addr,
	input  fspa_cmd_t              cmd,
	output fspa_sts_t              sts,
	output logic [OUT_DATA_W-1:0]  out_data,
	output logic [STATUS_W-1:0]    out_status
);

	localparam int LIMIT = (REGION_BYTES < ADDR_SPACE) ? REGION_BYTES : ADDR_SPACE;
	localparam int CHUNK_HDR = (HEADER_BYTES + HDR_ROUND) & ~HDR_ROUND;
	localparam logic [SUM_W-1:0]  LIMIT_W   = SUM_W'(LIMIT);
	localparam logic [BASE_W-1:0] CHUNK_HDR_W = BASE_W'(CHUNK_HDR);
	localparam logic [SLOT_W-1:0] HDR_MIN_W = SLOT_W'(HEADER_BYTES);
	localparam logic [SLOT_W-1:0] ROUND_W   = SLOT_W'(ELEM_ROUND);

	logic [EB_W-1:0]    eb_q;
	logic [EPC_W-1:0]   epc_q;
	logic [ADDR_W-1:0]  head_q;
	logic [BUMP_W-1:0]  bump_q;
	logic [FREE_W-1:0]  carved_q;
	logic [FREE_W-1:0]  free_q;
	logic [CHUNK_W-1:0] chunks_q;

	logic               op_q;
	logic [ADDR_W-1:0]  faddr_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [EPC_W-1:0]   n_q;
	logic [PROD_W-1:0]  prod_q;
	logic [BASE_W-1:0]  base_q;
	logic [BUMP_W-1:0]  end_q;
	logic [ADDR_W-1:0]  walk_addr_q;
	logic [EPC_W-1:0]   walk_cnt_q;
	logic [ADDR_W-1:0]  elem_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  rd_data_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic [ADDR_W-1:0]  link_mem [LINK_DEPTH];

	logic [SLOT_W-1:0]  size_min;
	logic [SLOT_W-1:0]  slot;
	logic [EPC_W-1:0]   n_eff;
	logic [SUM_W-1:0]   chunk_end;
	logic               fits;
	logic               push_ok;
	logic               mem_we;
	logic [LINK_AW-1:0] mem_waddr;

	always_comb begin
		size_min  = ({1'b0, eb_q} < HDR_MIN_W) ? HDR_MIN_W : {1'b0, eb_q};
		slot      = (size_min + ROUND_W) & ~ROUND_W;
		n_eff     = (epc_q == '0) ? EPC_W'(1) : epc_q;
		chunk_end = SUM_W'(base_q) + SUM_W'(prod_q);
		fits      = chunk_end <= LIMIT_W;
		push_ok   = (faddr_q != '0) && (free_q < carved_q);
		mem_we    = cmd.walk || (cmd.do_free && push_ok);
		mem_waddr = cmd.walk ? walk_addr_q[ADDR_W-1:2] : faddr_q[ADDR_W-1:2];
	end

	assign sts.op_free   = (op_q == OP_FREE);
	assign sts.head_zero = (head_q == '0);
	assign sts.fits      = fits;
	assign sts.walk_last = (walk_cnt_q == '0);

	// The link of each free element holds the element that was on top before it.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= head_q;
		end
		if (cmd.issue_read) begin
			rd_data_q <= link_mem[head_q[ADDR_W-1:2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eb_q     <= ELEM_BYTES_RST;
			epc_q    <= ELEMS_PER_CHUNK_RST;
			head_q   <= '0;
			bump_q   <= '0;
			carved_q <= '0;
			free_q   <= '0;
			chunks_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ELEMENT_BYTES:   eb_q  <= cfg_data;
					REG_ELEMS_PER_CHUNK: epc_q <= cfg_data[EPC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.do_free && push_ok) begin
				head_q <= faddr_q;
				free_q <= free_q + FREE_W'(1);
			end
			if (cmd.walk) begin
				head_q <= walk_addr_q;
				if (walk_cnt_q == '0) begin
					bump_q   <= end_q;
					carved_q <= carved_q + FREE_W'(n_q);
					free_q   <= free_q + FREE_W'(n_q);
					chunks_q <= chunks_q + CHUNK_W'(1);
				end
			end
			if (cmd.pop) begin
				head_q <= rd_data_q;
				free_q <= free_q - FREE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q    <= in_op;
			faddr_q <= in_addr;
		end
		if (cmd.do_free) begin
			elem_q <= '0;
			if (faddr_q == '0) begin
				status_q <= ST_NULL_FREE;
			end else if (!push_ok) begin
				status_q <= ST_OVER_FREE;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (cmd.mul) begin
			slot_q <= slot;
			n_q    <= n_eff;
			prod_q <= PROD_W'(slot) * PROD_W'(n_eff);
			base_q <= BASE_W'(bump_q) + CHUNK_HDR_W;
		end
		if (cmd.check) begin
			walk_addr_q <= base_q[ADDR_W-1:0];
			walk_cnt_q  <= n_q - EPC_W'(1);
			end_q       <= chunk_end[BUMP_W-1:0];
			if (!fits) begin
				elem_q   <= '0;
				status_q <= ST_EXHAUSTED;
			end
		end
		if (cmd.walk) begin
			walk_addr_q <= walk_addr_q + ADDR_W'(slot_q);
			walk_cnt_q  <= walk_cnt_q - EPC_W'(1);
		end
		if (cmd.pop) begin
			elem_q   <= head_q;
			status_q <= ST_OK;
		end
		if (cmd.load_out) begin
			out_data_q   <= {3'b000, chunks_q, free_q, elem_q};
			out_status_q <= status_q;
		end
	end

	assign out_data   = out_data_q;
	assign out_status = out_status_q;

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> free_q == $past(free_q) - FREE_W'(1))
		else $error("free count not decremented by a pop");

	a_check_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> $past(cmd.mul))
		else $error("region check without a fresh product");

	a_free_pushes_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_free && push_ok) |=> head_q == $past(faddr_q))
		else $error("freed address not placed on top of the list");

endmodule

[sv/fspa_ctrl.sv]
// Controller of the pool allocator: sequences each request through the datapath
// and owns the result valid flag. Depends on fspa_pkg.
module fspa_ctrl import fspa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fspa_sts_t sts,
	output fspa_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_WALK   = 7'b0010000,
		S_POP    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nxt    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op_free) begin
					cmd.do_free = 1'b1;
					state_nxt   = S_OUT;
				end else if (sts.head_zero) begin
					state_nxt = S_MUL;
				end else begin
					cmd.issue_read = 1'b1;
					state_nxt      = S_POP;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nxt = sts.fits ? S_WALK : S_OUT;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				// With the chunk on the list, the allocation is retried as a pop.
				if (sts.walk_last) begin
					state_nxt = S_DECODE;
				end
			end
			S_POP: begin
				cmd.pop   = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over one not yet taken");

	a_walk_fills_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && sts.walk_last) |=> !sts.head_zero)
		else $error("free list still empty after carving a chunk");

	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> $past(cmd.issue_read))
		else $error("pop without a link read in the cycle before");

	a_one_request_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |=> !in_ready)
		else $error("second request taken while one is in progress");

endmodule

[sv/fixed_size_pool_allocator_core.sv]
// Fixed-size pool allocator. Each request (allocate or free) yields one result. An
// allocation from a non-empty free list and a free each make one access to the
// link store plus the result hand-off. An allocation that finds the list empty
// first carves a chunk of N elements, N being the elements per chunk, and then
// pops from it; the link store takes one element write per cycle. If the region
// is exhausted, the carve ends without a write. A finished result waits in the output
// register while the next request is taken. Configuration writes apply at the next carve.
module fixed_size_pool_allocator_core import fspa_pkg::*; #(
	parameter int REGION_BYTES = REGION_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ADDR_W-1:0]     s_tdata,   // free_addr
	input  logic [0:0]            s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // elem_addr, free_count, chunk_count, zero pad
	output logic [STATUS_W-1:0]   m_tuser    // status
);

	fspa_cmd_t cmd;
	fspa_sts_t sts;

	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fspa_dp #(
		.REGION_BYTES (REGION_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_op      (s_tuser[0]),
		.in_addr    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule
